/* sv/wpmh_pkg.sv */
package wpmh_pkg;

  // block sizing
  localparam int WINDOW   = 8;
  localparam int CHANNELS = 32;

  // fixed field widths
  localparam int CHAN_W   = 5;
  localparam int SAMPLE_W = 16;

  // derived widths
  localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W    = CH_AW + PTR_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  typedef logic [CHAN_W-1:0]          chan_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [CH_AW-1:0]           ch_idx_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  localparam ptr_t PTR_LAST = ptr_t'(WINDOW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // control from the sequencer to the peak tracker
  typedef struct packed {
    logic clr;
    logic acc;
  } scan_ctl_t;

  function automatic logic ch_present(input chan_t ch);
    return (int'(ch) < CHANNELS);
  endfunction

  // row index of a channel, zero extended or truncated to the table size
  function automatic ch_idx_t ch_index(input chan_t ch);
    logic [CH_AW+CHAN_W-1:0] wide;
    wide = {{CH_AW{1'b0}}, ch};
    return wide[CH_AW-1:0];
  endfunction

endpackage

/* sv/wpmh_if.sv */
interface wpmh_in_if;
  logic               valid;
  logic               ready;
  wpmh_pkg::chan_t    channel;
  wpmh_pkg::sample_t  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface wpmh_out_if;
  logic               valid;
  logic               ready;
  wpmh_pkg::chan_t    channel_out;
  wpmh_pkg::sample_t  smoothed;

  modport source (output valid, output channel_out, output smoothed, input ready);
  modport sink   (input valid, input channel_out, input smoothed, output ready);
endinterface

/* sv/windowed_peak_magnitude_hold.sv */
// channel   dir  handshake      payload
// in_chan   in   valid/ready    channel (5b), sample (16b signed Q1.15)
// out_chan  out  valid/ready    channel_out (5b), smoothed (16b signed Q1.15)
//
// an item runs as a transfer in which the sample is written to the window
// memory, a scan reading each slot of the channel's ring through the single
// read port, and a flush folding the last word; no new item is taken until the flush is done
// an absent channel number skips the scan, goes to the flush and reports zero
// synchronous active-low reset clears the write pointers and fill flags, no transfer while held
// a result stalled at the output register holds the sequencer in its last state
module windowed_peak_magnitude_hold (
  input  logic        clk,
  input  logic        rst_n,
  wpmh_in_if.sink     in_chan,
  wpmh_out_if.source  out_chan
);
  import wpmh_pkg::*;

  // sequencer state
  state_t      state_r, state_nxt;

  // per-channel ring pointer and wrapped flag
  ptr_t                wp_r [CHANNELS];
  logic [CHANNELS-1:0] full_r;

  // item being worked on
  chan_t       ch_r;
  ptr_t        p_r;        // slot written by this item
  logic        full_q_r;   // ring had wrapped before this item
  ptr_t        rd_idx_r;
  logic        rd_vld_r;   // read data qualifies for the fold

  // output register
  logic        out_valid_r;
  chan_t       out_channel_r;
  sample_t     out_smoothed_r;

  // handshake and datapath controls
  logic        accept;
  logic        in_ok;
  ch_idx_t     in_idx;
  ptr_t        in_wp;
  ptr_t        in_wp_next;
  logic        out_free;
  logic        out_load;
  logic        rd_en;
  logic        entry_ok;
  addr_t       waddr;
  addr_t       raddr;
  sample_t     rd_data;
  sample_t     peak;
  scan_ctl_t   scan_ctl;

  assign in_idx     = ch_index(in_chan.channel);
  assign in_ok      = ch_present(in_chan.channel);
  assign in_wp      = wp_r[in_idx];
  assign in_wp_next = (in_wp == PTR_LAST) ? '0 : ptr_t'(in_wp + 1'b1);
  assign accept     = in_chan.valid && in_chan.ready;
  assign out_free   = !out_valid_r || out_chan.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_ok ? ST_SCAN : ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (rd_idx_r == PTR_LAST) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_chan.ready = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE:  in_chan.ready = rst_n;
      ST_SCAN:  rd_en         = 1'b1;
      ST_FLUSH: out_load      = out_free;
      default: begin
        in_chan.ready = 1'b0;
      end
    endcase
  end

  // slots past the write point of a ring that never wrapped are kept out of the fold, so they count as zero
  assign entry_ok = full_q_r || (rd_idx_r <= p_r);

  // the new sample is written on its transfer edge, ahead of every scan read
  assign waddr = {in_idx, in_wp};
  assign raddr = {ch_index(ch_r), rd_idx_r};

  assign scan_ctl.clr = accept;
  assign scan_ctl.acc = rd_vld_r;

  wpmh_store u_store (
    .clk   (clk),
    .we    (accept && in_ok),
    .waddr (waddr),
    .wdata (in_chan.sample),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  wpmh_scan u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .rd_data (rd_data),
    .result  (peak)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      full_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en && entry_ok;
      if (accept && in_ok) begin
        wp_r[in_idx] <= in_wp_next;
        if (in_wp == PTR_LAST) begin
          full_r[in_idx] <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-item payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r     <= in_chan.channel;
      p_r      <= in_wp;
      full_q_r <= full_r[in_idx];
      rd_idx_r <= '0;
    end else if (rd_en) begin
      rd_idx_r <= ptr_t'(rd_idx_r + 1'b1);
    end
    if (out_load) begin
      out_channel_r  <= ch_r;
      out_smoothed_r <= peak;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.channel_out = out_channel_r;
  assign out_chan.smoothed    = out_smoothed_r;

endmodule

/* sv/wpmh_store.sv */
module wpmh_store (
  input  logic              clk,
  input  logic              we,
  input  wpmh_pkg::addr_t   waddr,
  input  wpmh_pkg::sample_t wdata,
  input  logic              re,
  input  wpmh_pkg::addr_t   raddr,
  output wpmh_pkg::sample_t rdata
);
  import wpmh_pkg::*;

  sample_t mem [MEM_DEPTH];
  sample_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/wpmh_scan.sv */
module wpmh_scan (
  input  logic                  clk,
  input  wpmh_pkg::scan_ctl_t   ctl,
  input  wpmh_pkg::sample_t     rd_data,
  output wpmh_pkg::sample_t     result
);
  import wpmh_pkg::*;

  sample_t            best_r;
  sample_t            best_nxt;
  logic [SAMPLE_W:0]  mag_v;
  logic [SAMPLE_W:0]  mag_b;

  // larger magnitude wins, positive wins a magnitude tie
  always_comb begin
    mag_v = rd_data[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({rd_data[SAMPLE_W-1], rd_data}))
                                : {1'b0, rd_data};
    mag_b = best_r[SAMPLE_W-1]  ? (SAMPLE_W+1)'(-$signed({best_r[SAMPLE_W-1], best_r}))
                                : {1'b0, best_r};
    if ((mag_v > mag_b) || ((mag_v == mag_b) && (rd_data > best_r))) begin
      best_nxt = rd_data;
    end else begin
      best_nxt = best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      best_r <= '0;
    end else if (ctl.acc) begin
      best_r <= best_nxt;
    end
  end

  assign result = ctl.acc ? best_nxt : best_r;

endmodule

/* tb/sv/windowed_peak_magnitude_hold_tb.sv */
module windowed_peak_magnitude_hold_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpmh_pkg::*;

  logic clk;
  logic rst_n;

  wpmh_in_if  in_chan ();
  wpmh_out_if out_chan ();

  windowed_peak_magnitude_hold dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // one expected smoothed value, tagged with its channel
  typedef struct {
    chan_t   channel;
    sample_t peak;
  } peak_result_t;

  // per-channel sample rings plus the queue of peaks still owed by the block
  class peak_hold_board;
    sample_t      ring [CHANNELS][WINDOW];
    int unsigned  wr_ptr [CHANNELS];
    peak_result_t pending_peaks [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  noted;

    function new();
      for (int c = 0; c < CHANNELS; c++) begin
        wr_ptr[c] = 0;
        for (int i = 0; i < WINDOW; i++) ring[c][i] = '0;
      end
      mismatches = 0;
      checked    = 0;
      noted      = 0;
    endfunction

    // write the sample into its ring, then scan for the largest magnitude
    function sample_t window_peak(chan_t ch, sample_t s);
      int      c;
      int      best;
      int      v;
      int      mv;
      int      mb;
      c = int'(ch);
      if (c >= CHANNELS) return '0;  // absent channel: no state change, zero out
      ring[c][wr_ptr[c]] = s;
      wr_ptr[c] = (wr_ptr[c] + 1 >= WINDOW) ? 0 : wr_ptr[c] + 1;
      best = int'(ring[c][0]);
      for (int i = 1; i < WINDOW; i++) begin
        v  = int'(ring[c][i]);
        mv = (v < 0) ? -v : v;
        mb = (best < 0) ? -best : best;
        // equal magnitude: the positive one wins
        if (mv > mb || (mv == mb && v > best)) best = v;
      end
      return sample_t'(best);
    endfunction

    function void note_sample(chan_t ch, sample_t s);
      peak_result_t r;
      r.channel = ch;
      r.peak    = window_peak(ch, s);
      pending_peaks.push_back(r);
      noted++;
    endfunction

    function void check_peak(chan_t ch, sample_t v);
      peak_result_t e;
      if (pending_peaks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: channel %0d smoothed %0d", $time, ch, v);
        return;
      end
      e = pending_peaks.pop_front();
      checked++;
      if (ch !== e.channel || v !== e.peak) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: channel exp %0d got %0d, smoothed exp %0d got %0d",
                   $time, e.channel, ch, e.peak, v);
      end
    endfunction

    // some value currently held in a channel's ring, used to build ties
    function sample_t stored(chan_t ch);
      if (int'(ch) >= CHANNELS) return '0;
      return ring[int'(ch)][$urandom_range(0, WINDOW - 1)];
    endfunction
  endclass

  peak_hold_board sb = new();

  int unsigned drain_pauses;
  bit          sender_busy_phase;  // stretch with no gaps on the input side

  // clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard limit on the whole run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // gap lengths: mostly none or short, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one input transfer, driven at the falling edge, accepted at a rising edge
  task automatic send_item(input chan_t ch, input sample_t s);
    int gap;
    @(negedge clk);
    in_chan.valid   <= 1'b1;
    in_chan.channel <= ch;
    in_chan.sample  <= s;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_sample(ch, s);
    gap = sender_busy_phase ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // sender holds off until every owed result is out
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending_peaks.size() != 0) @(posedge clk);
    drain_pauses++;
  endtask

  // result side: ready drops for random stalls, with stall-free phases between
  initial begin
    int stall_left;
    int phase_cnt;
    bit stalls_on;
    out_chan.ready = 1'b0;
    stall_left = 0;
    phase_cnt  = 0;
    stalls_on  = 1'b1;
    forever begin
      @(negedge clk);
      phase_cnt++;
      if (phase_cnt % 400 == 0) stalls_on = ~stalls_on;
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_peak(out_chan.channel_out, out_chan.smoothed);
  end

  // stimulus
  initial begin
    sample_t extremes [6];
    int      hot [4];
    int      n_random;
    chan_t   ch;
    sample_t s;
    int      kind;

    extremes[0] = 16'sh7FFF;
    extremes[1] = 16'sh8001;
    extremes[2] = 16'sh8000;
    extremes[3] = 16'sh0000;
    extremes[4] = 16'sh0001;
    extremes[5] = 16'shFFFF;
    drain_pauses      = 0;
    sender_busy_phase = 1'b0;
    n_random          = 1400;

    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.channel = '0;
    in_chan.sample  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full-scale tie on a fresh ring, positive first then negative
    send_item(5'd0, 16'sh7FFF);
    send_item(5'd0, 16'sh8001);
    // same tie with the negative one written first
    send_item(5'd1, 16'sh8001);
    send_item(5'd1, 16'sh7FFF);
    // most negative sample beats everything
    send_item(5'd2, 16'sh8000);
    send_item(5'd2, 16'sh7FFF);
    // flag channel at the top channel number
    send_item(5'd31, 16'sh0001);
    send_item(5'd31, 16'sh0000);
    // zero into an untouched ring
    send_item(5'd30, 16'sh0000);
    // small tie, then a larger negative takes over
    send_item(5'd5, -16'sd5);
    send_item(5'd5, 16'sd5);
    send_item(5'd5, -16'sd6);
    // wrap the ring on channel 2 so the most negative sample ages out
    send_item(5'd2, 16'sh5555);
    send_item(5'd2, 16'shAAAB);
    send_item(5'd2, 16'sh0F0F);
    send_item(5'd2, 16'shF0F1);
    send_item(5'd2, 16'sh0100);
    send_item(5'd2, 16'shFF00);
    send_item(5'd2, 16'sh0000);
    send_item(5'd2, 16'sh2AAA);
    drain_results();

    // random part: mostly a few busy channels so rings wrap many times
    for (int k = 0; k < 4; k++) hot[k] = $urandom_range(0, 31);
    for (int n = 0; n < n_random; n++) begin
      if (n % 200 == 0)
        for (int k = 0; k < 4; k++) hot[k] = $urandom_range(0, 31);
      if (n % 150 == 0) sender_busy_phase = ($urandom_range(0, 3) == 0);
      if (n % 350 == 349) drain_results();
      if ($urandom_range(0, 9) < 7) ch = chan_t'(hot[$urandom_range(0, 3)]);
      else ch = chan_t'($urandom_range(0, 31));
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          s = extremes[$urandom_range(0, 5)];
        end
        1: begin
          s = sample_t'($urandom_range(0, 1));
        end
        2: begin
          s = -sb.stored(ch);  // builds equal-magnitude ties
        end
        3, 4: begin
          s = sample_t'(int'($urandom_range(0, 512)) - 256);
        end
        default: begin
          s = sample_t'($urandom());
        end
      endcase
      send_item(ch, s);
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending_peaks.size() != 0) @(posedge clk);
    // room for a result still in flight
    repeat (4 * (WINDOW + 2)) @(posedge clk);

    $display("covered %0d samples over all %0d channels, %0d peaks checked",
             sb.noted, CHANNELS, sb.checked);
    $display("ties, full-scale and flag samples, ring wraps, %0d drain pauses, random stalls",
             drain_pauses);
    if (sb.mismatches == 0 && sb.pending_peaks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("mismatches %0d, results still owed %0d", sb.mismatches,
               sb.pending_peaks.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
